>>> hdl/rhr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhr_pkg: shared types and constants of the RGB hue rotation unit
// Channel and hue widths, the pixel word types, the hue sector codes and the
// shape of the pipelined restoring divider.
// ----------------------------------------------------------------------------
package rhr_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 16;

   // The shift covers one full turn either way: six sectors plus a sign bit.
   localparam int SHIFT_BITS = HUE_FRAC_BITS + 4;
   // Quotients of the two divisions run from 0 to exactly one (2^F).
   localparam int QUO_BITS   = HUE_FRAC_BITS + 1;
   // A wrapped hue runs from 0 to 6*2^F - 1.
   localparam int HUE_BITS   = HUE_FRAC_BITS + 3;
   // Hue plus shift before the wrap.
   localparam int SUM_BITS   = SHIFT_BITS + 1;

   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES =
      (QUO_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

   localparam logic [QUO_BITS-1:0] HUE_ONE  = QUO_BITS'(1) << HUE_FRAC_BITS;
   localparam logic [HUE_BITS-1:0] HUE_TURN = HUE_BITS'(6) << HUE_FRAC_BITS;

   typedef enum logic [2:0] {
      SECT_RED     = 3'd0,
      SECT_YELLOW  = 3'd1,
      SECT_GREEN   = 3'd2,
      SECT_CYAN    = 3'd3,
      SECT_BLUE    = 3'd4,
      SECT_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      logic        [CHANNEL_BITS-1:0] red_in;
      logic        [CHANNEL_BITS-1:0] green_in;
      logic        [CHANNEL_BITS-1:0] blue_in;
      logic signed [SHIFT_BITS-1:0]   hue_shift;
   } pixel_in_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_out;
      logic [CHANNEL_BITS-1:0] green_out;
      logic [CHANNEL_BITS-1:0] blue_out;
   } pixel_out_type;

endpackage
`default_nettype wire

>>> hdl/rgb_hue_rotate_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_hue_rotate_unit: hue rotation of one RGB pixel through HSV space
// Converts a pixel to fixed-point HSV, adds a signed hue shift modulo a full
// turn and converts back, one pixel word per clock while rsp_stall is low.
// ----------------------------------------------------------------------------
// Path: a word accepted at the input passes through 11 register stages before
// it appears on rsp_valid.
// Throughput: one word per cycle, sustained while rsp_stall is low; every stage
// takes a new word each cycle, the two dividers included, which spread their 17
// quotient bits over five stages (four bits per stage, one in the last).
// Reset clears the valid bit of every stage; the data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_hue_rotate_unit
   import rhr_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  wire           pixel_in_type req_data,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output pixel_out_type rsp_data
);

   // Stage map. The prep stage finds max, min and the sector, the divider
   // stages form saturation and the in-sector hue fraction, then come the
   // hue sum, the wrap, two multiply stages and the output register.
   localparam int ST_PREP     = 0;
   localparam int ST_DIV_LAST = DIV_STAGES;
   localparam int ST_HSUM     = DIV_STAGES + 1;
   localparam int ST_HWRAP    = DIV_STAGES + 2;
   localparam int ST_MUL1     = DIV_STAGES + 3;
   localparam int ST_MUL2     = DIV_STAGES + 4;
   localparam int ST_OUT      = DIV_STAGES + 5;
   localparam int NUM_STAGES  = DIV_STAGES + 6;

   // Data that rides alongside the dividers.
   typedef struct packed {
      pixel_in_type            pixel;
      logic [CHANNEL_BITS-1:0] value;
      sector_type              base;
      logic                    negative;
      logic                    grey;
   } side_type;

   // Data that rides from the hue sum to the output stage.
   typedef struct packed {
      pixel_out_type           grey_pix;
      logic [CHANNEL_BITS-1:0] value;
      logic                    grey;
   } tail_type;

   // ------------------------------------------------------------------
   // Flow control. Each stage takes a new word when it is empty or when
   // the stage after it moves, so bubbles close up even while the output
   // word is stalled.
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready;

   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[ST_OUT];

   // ------------------------------------------------------------------
   // Prep stage: value is the largest channel, with red winning ties over
   // green and green over blue. The numerator of the in-sector fraction is
   // the difference of the two other channels, kept as sign and magnitude.
   // ------------------------------------------------------------------
   logic [CHANNEL_BITS-1:0] max_in;
   logic [CHANNEL_BITS-1:0] min_in;
   logic [CHANNEL_BITS-1:0] delta_in;
   logic [CHANNEL_BITS-1:0] absnum_in;
   logic signed [CHANNEL_BITS:0] num_in;
   sector_type              base_in;
   side_type                side_in;

   side_type                side_ff [DIV_STAGES+1];
   logic [CHANNEL_BITS-1:0] delta_ff;
   logic [CHANNEL_BITS-1:0] absnum_ff;

   always_comb begin
      logic [CHANNEL_BITS-1:0] r;
      logic [CHANNEL_BITS-1:0] g;
      logic [CHANNEL_BITS-1:0] b;
      r = req_data.red_in;
      g = req_data.green_in;
      b = req_data.blue_in;
      if (r >= g && r >= b) begin
         max_in  = r;
         base_in = SECT_RED;
         num_in  = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (g >= b) begin
         max_in  = g;
         base_in = SECT_GREEN;
         num_in  = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         max_in  = b;
         base_in = SECT_BLUE;
         num_in  = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      if (r <= g && r <= b) begin
         min_in = r;
      end else if (g <= b) begin
         min_in = g;
      end else begin
         min_in = b;
      end
      delta_in = max_in - min_in;
      if (num_in[CHANNEL_BITS]) begin
         absnum_in = CHANNEL_BITS'(-num_in);
      end else begin
         absnum_in = num_in[CHANNEL_BITS-1:0];
      end
      side_in.pixel    = req_data;
      side_in.value    = max_in;
      side_in.base     = base_in;
      side_in.negative = num_in[CHANNEL_BITS];
      side_in.grey     = (delta_in == '0);
   end

   always_ff @(posedge clock) begin
      if (ready[ST_PREP]) begin
         delta_ff            <= delta_in;
         absnum_ff           <= absnum_in;
      end
   end

   // ------------------------------------------------------------------
   // Divider stages. Saturation is delta/max and the in-sector hue is
   // |num|/delta, both as fractions of one. A grey pixel may divide by
   // zero here; its result is replaced by the input pixel at the end.
   // ------------------------------------------------------------------
   logic [QUO_BITS-1:0] sat_q;
   logic [QUO_BITS-1:0] mag_q;

   rhr_divider u_sat_div (
      .clock    (clock),
      .advance  (ready[ST_DIV_LAST:1]),
      .dividend (delta_ff),
      .divisor  (side_ff[0].value),
      .quotient (sat_q)
   );

   rhr_divider u_mag_div (
      .clock    (clock),
      .advance  (ready[ST_DIV_LAST:1]),
      .dividend (absnum_ff),
      .divisor  (delta_ff),
      .quotient (mag_q)
   );

   // The side data enters with the prep stage and then walks beside the
   // dividers.
   always_ff @(posedge clock) begin
      if (ready[ST_PREP]) begin
         side_ff[0] <= side_in;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         if (ready[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Hue sum: sector base plus or minus the in-sector fraction, with a
   // full turn added when red leads and the fraction is negative, then
   // the shift added on.
   // ------------------------------------------------------------------
   logic [HUE_BITS-1:0] hue_raw_in;
   logic [SUM_BITS-1:0] sum_in;
   logic [SUM_BITS-1:0] sum_ff;
   logic [QUO_BITS-1:0] sat_sum_ff;
   tail_type            tail_ff [4];

   always_comb begin
      logic [HUE_BITS-1:0] base_hue;
      side_type            sd;
      sd       = side_ff[DIV_STAGES];
      base_hue = {sd.base, {HUE_FRAC_BITS{1'b0}}};
      if (!sd.negative) begin
         hue_raw_in = base_hue + HUE_BITS'(mag_q);
      end else if (sd.base == SECT_RED) begin
         hue_raw_in = HUE_TURN - HUE_BITS'(mag_q);
      end else begin
         hue_raw_in = base_hue - HUE_BITS'(mag_q);
      end
      sum_in = {2'b00, hue_raw_in}
             + {sd.pixel.hue_shift[SHIFT_BITS-1], sd.pixel.hue_shift};
   end

   always_ff @(posedge clock) begin
      if (ready[ST_HSUM]) begin
         sum_ff                 <= sum_in;
         sat_sum_ff             <= sat_q;
         tail_ff[0].grey_pix    <= '{red_out:   side_ff[DIV_STAGES].pixel.red_in,
                                     green_out: side_ff[DIV_STAGES].pixel.green_in,
                                     blue_out:  side_ff[DIV_STAGES].pixel.blue_in};
         tail_ff[0].value       <= side_ff[DIV_STAGES].value;
         tail_ff[0].grey        <= side_ff[DIV_STAGES].grey;
      end
   end

   // ------------------------------------------------------------------
   // Wrap: with the shift held to one turn either way, one add or subtract
   // of a turn brings the sum into 0..turn-1; wider shifts are not clamped.
   // ------------------------------------------------------------------
   logic [HUE_BITS-1:0] hue_in;
   logic [HUE_BITS-1:0] hue_ff;
   logic [QUO_BITS-1:0] sat_wrap_ff;

   always_comb begin
      logic [SUM_BITS-1:0] turn_ext;
      logic [SUM_BITS-1:0] fixed;
      turn_ext = SUM_BITS'(HUE_TURN);
      if (sum_ff[SUM_BITS-1]) begin
         fixed = sum_ff + turn_ext;
      end else if (sum_ff >= turn_ext) begin
         fixed = sum_ff - turn_ext;
      end else begin
         fixed = sum_ff;
      end
      hue_in = fixed[HUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ready[ST_HWRAP]) begin
         hue_ff      <= hue_in;
         sat_wrap_ff <= sat_sum_ff;
         tail_ff[1]  <= tail_ff[0];
      end
   end

   // ------------------------------------------------------------------
   // First multiply stage: the two saturation-weighted fractions and p.
   // ------------------------------------------------------------------
   logic [QUO_BITS-1:0]     sfrac_in;
   logic [QUO_BITS-1:0]     sfrac_inv_in;
   logic [CHANNEL_BITS-1:0] p_in;
   sector_type              sector_in;

   logic [QUO_BITS-1:0]     sfrac_ff;
   logic [QUO_BITS-1:0]     sfrac_inv_ff;
   logic [CHANNEL_BITS-1:0] p_ff;
   sector_type              sector_ff;

   always_comb begin
      logic [HUE_FRAC_BITS-1:0]              frac;
      logic [QUO_BITS-1:0]                   frac_inv;
      logic [QUO_BITS-1:0]                   sat_inv;
      logic [QUO_BITS+HUE_FRAC_BITS-1:0]     sf_full;
      logic [2*QUO_BITS-1:0]                 sfi_full;
      logic [CHANNEL_BITS+QUO_BITS-1:0]      p_full;
      frac      = hue_ff[HUE_FRAC_BITS-1:0];
      frac_inv  = HUE_ONE - {1'b0, frac};
      sat_inv   = HUE_ONE - sat_wrap_ff;
      sf_full   = (QUO_BITS+HUE_FRAC_BITS)'(sat_wrap_ff)
                * (QUO_BITS+HUE_FRAC_BITS)'(frac);
      sfi_full  = (2*QUO_BITS)'(sat_wrap_ff) * (2*QUO_BITS)'(frac_inv);
      p_full    = (CHANNEL_BITS+QUO_BITS)'(tail_ff[1].value)
                * (CHANNEL_BITS+QUO_BITS)'(sat_inv);
      sfrac_in     = sf_full[QUO_BITS+HUE_FRAC_BITS-1:HUE_FRAC_BITS];
      sfrac_inv_in = sfi_full[QUO_BITS+HUE_FRAC_BITS-1:HUE_FRAC_BITS];
      p_in         = p_full[CHANNEL_BITS+HUE_FRAC_BITS-1:HUE_FRAC_BITS];
      sector_in    = sector_type'(hue_ff[HUE_BITS-1:HUE_FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (ready[ST_MUL1]) begin
         sfrac_ff     <= sfrac_in;
         sfrac_inv_ff <= sfrac_inv_in;
         p_ff         <= p_in;
         sector_ff    <= sector_in;
         tail_ff[2]   <= tail_ff[1];
      end
   end

   // ------------------------------------------------------------------
   // Second multiply stage: q and t scale the value by what is left of
   // one after the weighted fractions.
   // ------------------------------------------------------------------
   logic [CHANNEL_BITS-1:0] q_in;
   logic [CHANNEL_BITS-1:0] t_in;

   logic [CHANNEL_BITS-1:0] q_ff;
   logic [CHANNEL_BITS-1:0] t_ff;
   logic [CHANNEL_BITS-1:0] p_mul_ff;
   sector_type              sector_mul_ff;

   always_comb begin
      logic [CHANNEL_BITS+QUO_BITS-1:0] q_full;
      logic [CHANNEL_BITS+QUO_BITS-1:0] t_full;
      q_full = (CHANNEL_BITS+QUO_BITS)'(tail_ff[2].value)
             * (CHANNEL_BITS+QUO_BITS)'(HUE_ONE - sfrac_ff);
      t_full = (CHANNEL_BITS+QUO_BITS)'(tail_ff[2].value)
             * (CHANNEL_BITS+QUO_BITS)'(HUE_ONE - sfrac_inv_ff);
      q_in   = q_full[CHANNEL_BITS+HUE_FRAC_BITS-1:HUE_FRAC_BITS];
      t_in   = t_full[CHANNEL_BITS+HUE_FRAC_BITS-1:HUE_FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (ready[ST_MUL2]) begin
         q_ff          <= q_in;
         t_ff          <= t_in;
         p_mul_ff      <= p_ff;
         sector_mul_ff <= sector_ff;
         tail_ff[3]    <= tail_ff[2];
      end
   end

   // ------------------------------------------------------------------
   // Output stage: the sector picks the channel order. Grey pixels,
   // black included, pass through unchanged whatever the shift.
   // ------------------------------------------------------------------
   pixel_out_type rsp_data_in;
   pixel_out_type rsp_data_ff;

   always_comb begin
      logic [CHANNEL_BITS-1:0] v;
      v = tail_ff[3].value;
      case (sector_mul_ff)
         SECT_RED:    rsp_data_in = '{red_out: v,        green_out: t_ff,
                                      blue_out: p_mul_ff};
         SECT_YELLOW: rsp_data_in = '{red_out: q_ff,     green_out: v,
                                      blue_out: p_mul_ff};
         SECT_GREEN:  rsp_data_in = '{red_out: p_mul_ff, green_out: v,
                                      blue_out: t_ff};
         SECT_CYAN:   rsp_data_in = '{red_out: p_mul_ff, green_out: q_ff,
                                      blue_out: v};
         SECT_BLUE:   rsp_data_in = '{red_out: t_ff,     green_out: p_mul_ff,
                                      blue_out: v};
         // Magenta, and the two codes a wrapped hue never produces.
         default:     rsp_data_in = '{red_out: v,        green_out: p_mul_ff,
                                      blue_out: q_ff};
      endcase
      if (tail_ff[3].grey) begin
         rsp_data_in = tail_ff[3].grey_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[ST_OUT]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_stall_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while the output stage is empty");

   a_quotients_in_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_DIV_LAST] && !side_ff[DIV_STAGES].grey)
         |-> (sat_q <= HUE_ONE && mag_q <= HUE_ONE))
      else $error("divider quotient exceeds one");

   a_hue_wrapped: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_HWRAP] |-> (hue_ff < HUE_TURN))
      else $error("wrapped hue outside one turn");

   a_hue_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_HWRAP] && !ready[ST_HWRAP+1])
         |=> (valid_ff[ST_HWRAP] && $stable(hue_ff)))
      else $error("stalled hue stage lost or changed its word");

   a_products_bounded: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_MUL2] && !tail_ff[3].grey)
         |-> (p_mul_ff <= tail_ff[3].value && q_ff <= tail_ff[3].value
              && t_ff <= tail_ff[3].value))
      else $error("p, q or t exceeds the value channel");

endmodule
`default_nettype wire

>>> hdl/rhr_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhr_divider: pipelined fraction divider
// Computes floor(dividend * 2^F / divisor) for dividend <= divisor by
// restoring division, DIV_STEPS_PER_STAGE quotient bits per register stage.
// ----------------------------------------------------------------------------
module rhr_divider
   import rhr_pkg::*;
(
   input  wire                     clock,
   input  wire [DIV_STAGES-1:0]    advance,
   input  wire [CHANNEL_BITS-1:0]  dividend,
   input  wire [CHANNEL_BITS-1:0]  divisor,
   output logic [QUO_BITS-1:0]     quotient
);

   logic [CHANNEL_BITS-1:0] rem_ff [DIV_STAGES-1];
   logic [CHANNEL_BITS-1:0] den_ff [DIV_STAGES-1];
   logic [QUO_BITS-1:0]     quo_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [CHANNEL_BITS-1:0] rem_src;
      logic [CHANNEL_BITS-1:0] den_src;
      logic [QUO_BITS-1:0]     quo_src;
      logic [CHANNEL_BITS-1:0] rem_in;
      logic [QUO_BITS-1:0]     quo_in;

      if (s == 0) begin : g_first
         assign rem_src = dividend;
         assign den_src = divisor;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      // The first step compares the dividend itself and yields the integer
      // bit; every later step doubles the remainder first.
      always_comb begin
         logic [CHANNEL_BITS:0] trial;
         trial  = '0;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            if (s * DIV_STEPS_PER_STAGE + j < QUO_BITS) begin
               if (s * DIV_STEPS_PER_STAGE + j == 0) begin
                  trial = {1'b0, rem_in};
               end else begin
                  trial = {rem_in, 1'b0};
               end
               if (trial >= {1'b0, den_src}) begin
                  trial  = trial - {1'b0, den_src};
                  quo_in = {quo_in[QUO_BITS-2:0], 1'b1};
               end else begin
                  quo_in = {quo_in[QUO_BITS-2:0], 1'b0};
               end
               rem_in = trial[CHANNEL_BITS-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance[s]) begin
            quo_ff[s] <= quo_in;
         end
      end

      if (s < DIV_STAGES - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (advance[s]) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_src;
            end
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule
`default_nettype wire
